// ===== rtl/dmwpc_pkg.sv =====
package dmwpc_pkg;

  localparam int ADDR_BITS = 14;
  localparam int TYPE_BITS = 3;
  localparam int OPND_BITS = 32;
  localparam int DATA_BITS = 32;

  localparam logic [TYPE_BITS-1:0] KIND_READ  = 3'd0;
  localparam logic [TYPE_BITS-1:0] KIND_WRITE = 3'd1;
  localparam logic [TYPE_BITS-1:0] KIND_INC   = 3'd2;
  localparam logic [TYPE_BITS-1:0] KIND_ADD   = 3'd3;
  localparam logic [TYPE_BITS-1:0] KIND_DEC   = 3'd4;
  localparam logic [TYPE_BITS-1:0] KIND_SUB   = 3'd5;

  localparam logic STATUS_DONE    = 1'b0;
  localparam logic STATUS_REFUSED = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_TAG,
    ST_WB,
    ST_FILL,
    ST_READ,
    ST_MODIFY
  } state_t;

endpackage

// ===== rtl/dmwpc_req_if.sv =====
interface dmwpc_req_if;
  import dmwpc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [TYPE_BITS-1:0] req_type;
  logic [ADDR_BITS-1:0] word_address;
  logic [OPND_BITS-1:0] operand;

  modport source (output valid, req_type, word_address, operand, input ready);
  modport sink (input valid, req_type, word_address, operand, output ready);

endinterface

// ===== rtl/dmwpc_rsp_if.sv =====
interface dmwpc_rsp_if;
  import dmwpc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [DATA_BITS-1:0] data_out;
  logic                 status;
  logic                 was_hit;
  logic                 did_writeback;

  modport source (output valid, data_out, status, was_hit, did_writeback, input ready);
  modport sink (input valid, data_out, status, was_hit, did_writeback, output ready);

endinterface

// ===== rtl/dmwpc_cdiv.sv =====
module dmwpc_cdiv #(
  parameter int unsigned DIVISOR = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic [dmwpc_pkg::ADDR_BITS-1:0] dividend,
  output logic                           out_valid,
  output logic [dmwpc_pkg::ADDR_BITS-1:0] quotient,
  output logic [dmwpc_pkg::ADDR_BITS-1:0] remainder
);
  import dmwpc_pkg::*;

  localparam int N = ADDR_BITS;
  localparam bit BIG = longint'(DIVISOR) >= (longint'(1) << N);
  localparam bit POW2 = (DIVISOR & (DIVISOR - 1)) == 0;

  generate
    if (BIG || POW2) begin : g_shift
      // power of two or wider than any dividend: same cycle
      localparam int SH = BIG ? N : $clog2(DIVISOR);
      localparam logic [N-1:0] MASK = BIG ? '1 : N'(DIVISOR - 1);

      assign out_valid = in_valid;
      assign quotient  = dividend >> SH;
      assign remainder = dividend & MASK;
    end else begin : g_recip
      // reciprocal multiply gives q or q-1, then one correction step
      localparam int S = N + $clog2(DIVISOR);
      localparam int P = N + S;
      localparam longint unsigned RECIP = (longint'(1) << S) / DIVISOR;
      localparam logic [S-1:0] RECIP_S = S'(RECIP);
      localparam logic [N-1:0] DIV_N = N'(DIVISOR);

      logic [P-1:0] prod;
      logic [N-1:0] num_q;
      logic [N-1:0] est_q;
      logic         est_v;
      logic [N-1:0] back;
      logic [N-1:0] r_raw;

      assign prod  = P'(dividend) * P'(RECIP_S);
      assign back  = N'(est_q * DIV_N);
      assign r_raw = num_q - back;

      always_ff @(posedge clk) begin
        if (rst) begin
          est_v     <= 1'b0;
          out_valid <= 1'b0;
        end else begin
          est_v     <= in_valid;
          out_valid <= est_v;
        end
      end

      always_ff @(posedge clk) begin
        if (in_valid) begin
          num_q <= dividend;
          est_q <= N'(prod >> S);
        end
        if (est_v) begin
          if (r_raw >= DIV_N) begin
            quotient  <= est_q + N'(1);
            remainder <= r_raw - DIV_N;
          end else begin
            quotient  <= est_q;
            remainder <= r_raw;
          end
        end
      end
    end
  endgenerate

endmodule

// ===== rtl/direct_mapped_writeback_page_cache.sv =====
// channel  dir  handshake    payload
// req      in   valid/ready  req_type[2:0], word_address[13:0], operand[31:0]
// rsp      out  valid/ready  data_out[31:0], status, was_hit, did_writeback
//
// one word at a time: a hit goes from accept through the address split, the tag read and the
// update; each address split (by total size, by slot span, by page size) not a power of two
// adds its estimate and correction registers. a miss copies each page of WORDS_PER_PAGE words
// through the single-port memories, one copy for a clean slot and two for a dirty one, then
// rereads the word. after reset a clearing pass zeroes tags, resident and backing words: one
// entry a cycle over max(backing depth, RESIDENT_PAGES*WORDS_PER_PAGE) (16384 by default).
// a result waits in the output register; the next word is taken meanwhile and holds
// its final update until that register is free.
module direct_mapped_writeback_page_cache #(
  parameter int unsigned WORDS_PER_PAGE = 64,
  parameter int unsigned RESIDENT_PAGES = 16,
  parameter int unsigned PAGE_KEYS      = 16,
  parameter int unsigned WORD_BITS      = 32
) (
  input logic         clk,
  input logic         rst,
  dmwpc_req_if.sink   req,
  dmwpc_rsp_if.source rsp
);
  import dmwpc_pkg::*;

  localparam int unsigned TOTAL_WORDS = WORDS_PER_PAGE * RESIDENT_PAGES * PAGE_KEYS;
  localparam int unsigned ADDR_SPAN   = 1 << ADDR_BITS;
  localparam int unsigned REACH       = (TOTAL_WORDS < ADDR_SPAN) ? TOTAL_WORDS : ADDR_SPAN;
  localparam int unsigned RES_DEPTH   = RESIDENT_PAGES * WORDS_PER_PAGE;
  localparam int unsigned BACK_DEPTH  =
    ((REACH - 1) / WORDS_PER_PAGE + 1) * WORDS_PER_PAGE;
  localparam int unsigned CLR_DEPTH   = (BACK_DEPTH > RES_DEPTH) ? BACK_DEPTH : RES_DEPTH;

  localparam int KEY_W  = (PAGE_KEYS > 1) ? $clog2(PAGE_KEYS) : 1;
  localparam int SLOT_W = (RESIDENT_PAGES > 1) ? $clog2(RESIDENT_PAGES) : 1;
  localparam int RIDX_W = (RES_DEPTH > 1) ? $clog2(RES_DEPTH) : 1;
  localparam int BACK_W = (BACK_DEPTH > 1) ? $clog2(BACK_DEPTH) : 1;
  localparam int CLR_W  = (CLR_DEPTH > 1) ? $clog2(CLR_DEPTH) : 1;
  localparam int CNT_W  = $clog2(WORDS_PER_PAGE + 1);

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORDS_PER_PAGE);
  localparam logic [CLR_W-1:0] CLR_LAST = CLR_W'(CLR_DEPTH - 1);

  typedef struct packed {
    logic             dirty;
    logic [KEY_W-1:0] key;
  } tag_t;

  // storage
  logic [WORD_BITS-1:0] res_mem  [RES_DEPTH];
  logic [WORD_BITS-1:0] back_mem [BACK_DEPTH];
  tag_t                 tag_mem  [RESIDENT_PAGES];

  state_t state, state_next;
  logic [CLR_W-1:0] clr_cnt;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_prev;
  logic             dec_go;

  logic [TYPE_BITS-1:0] kind_q;
  logic [ADDR_BITS-1:0] addr_q;
  logic [WORD_BITS-1:0] opnd_q;

  logic [KEY_W-1:0]  key_q;
  logic [RIDX_W-1:0] ridx_q;
  logic [SLOT_W-1:0] slot_q;
  logic [RIDX_W-1:0] slot_base_q;
  logic [BACK_W-1:0] new_base_q;
  logic [BACK_W-1:0] old_base_q;
  logic              refuse_q;
  logic              hit_q;
  logic              wb_q;
  logic              old_dirty_q;

  logic                 out_valid;
  logic [DATA_BITS-1:0] out_data;
  logic                 out_status;
  logic                 out_hit;
  logic                 out_wb;

  // address split
  logic                 d1_v, d2_v, d3_v;
  logic [ADDR_BITS-1:0] d1_r, d2_q, d2_r, d3_q, d3_r;

  // memory ports
  logic                 res_re, res_we;
  logic [RIDX_W-1:0]    res_raddr, res_waddr;
  logic [WORD_BITS-1:0] res_wdata, res_rd;
  logic                 back_re, back_we;
  logic [BACK_W-1:0]    back_raddr, back_waddr;
  logic [WORD_BITS-1:0] back_wdata, back_rd;
  logic                 tag_re, tag_we;
  logic [SLOT_W-1:0]    tag_raddr, tag_waddr;
  tag_t                 tag_wdata, tag_rd;

  logic                 accept;
  logic                 refuse_now;
  logic                 tag_hit;
  logic                 modify;
  logic                 load;
  logic [WORD_BITS-1:0] new_word;

  // word address -> reduced address -> key and resident index -> slot and offset
  dmwpc_cdiv #(.DIVISOR(REACH)) u_div_total (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dec_go),
    .dividend  (addr_q),
    .out_valid (d1_v),
    .quotient  (),
    .remainder (d1_r)
  );

  dmwpc_cdiv #(.DIVISOR(RES_DEPTH)) u_div_span (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d1_v),
    .dividend  (d1_r),
    .out_valid (d2_v),
    .quotient  (d2_q),
    .remainder (d2_r)
  );

  dmwpc_cdiv #(.DIVISOR(WORDS_PER_PAGE)) u_div_page (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d2_v),
    .dividend  (d2_r),
    .out_valid (d3_v),
    .quotient  (d3_q),
    .remainder (d3_r)
  );

  assign req.ready  = (state == ST_IDLE);
  assign accept     = req.valid && req.ready;
  assign refuse_now = (kind_q == KIND_WRITE) && (d1_r == '0);
  assign tag_hit    = (tag_rd.key == key_q);
  assign modify     = kind_q inside {[KIND_WRITE:KIND_SUB]};
  assign cnt_prev   = cnt - CNT_W'(1);

  assign rsp.valid         = out_valid;
  assign rsp.data_out      = out_data;
  assign rsp.status        = out_status;
  assign rsp.was_hit       = out_hit;
  assign rsp.did_writeback = out_wb;

  always_comb begin
    case (kind_q)
      KIND_READ:  new_word = res_rd;
      KIND_WRITE: new_word = opnd_q;
      KIND_INC:   new_word = res_rd + WORD_BITS'(1);
      KIND_ADD:   new_word = res_rd + opnd_q;
      KIND_DEC:   new_word = res_rd - WORD_BITS'(1);
      KIND_SUB:   new_word = res_rd - opnd_q;
      default:    new_word = res_rd;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_cnt == CLR_LAST) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req.valid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        if (d3_v) state_next = refuse_now ? ST_MODIFY : ST_TAG;
      end
      ST_TAG: begin
        if (tag_hit) state_next = ST_MODIFY;
        else if (tag_rd.dirty) state_next = ST_WB;
        else state_next = ST_FILL;
      end
      ST_WB: begin
        if (cnt == CNT_LAST) state_next = ST_FILL;
      end
      ST_FILL: begin
        if (cnt == CNT_LAST) state_next = ST_READ;
      end
      ST_READ: begin
        state_next = ST_MODIFY;
      end
      ST_MODIFY: begin
        if (load) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // memory controls
  always_comb begin
    load       = (state == ST_MODIFY) && (!out_valid || rsp.ready);
    res_re     = 1'b0;
    res_raddr  = ridx_q;
    res_we     = 1'b0;
    res_waddr  = ridx_q;
    res_wdata  = new_word;
    back_re    = 1'b0;
    back_raddr = new_base_q + BACK_W'(cnt);
    back_we    = 1'b0;
    back_waddr = old_base_q + BACK_W'(cnt_prev);
    back_wdata = res_rd;
    tag_re     = (state == ST_DECODE) && d3_v;
    tag_raddr  = SLOT_W'(d3_q);
    tag_we     = 1'b0;
    tag_waddr  = slot_q;
    tag_wdata  = '{dirty: modify || (hit_q && old_dirty_q), key: key_q};
    case (state)
      ST_CLEAR: begin
        res_we     = 32'(clr_cnt) < RES_DEPTH;
        res_waddr  = RIDX_W'(clr_cnt);
        res_wdata  = '0;
        back_we    = 32'(clr_cnt) < BACK_DEPTH;
        back_waddr = BACK_W'(clr_cnt);
        back_wdata = '0;
        tag_we     = 32'(clr_cnt) < RESIDENT_PAGES;
        tag_waddr  = SLOT_W'(clr_cnt);
        tag_wdata  = '0;
      end
      ST_TAG: begin
        res_re = tag_hit;
      end
      ST_WB: begin
        // read word cnt, store word cnt-1 read just before it
        res_re    = (cnt != CNT_LAST);
        res_raddr = slot_base_q + RIDX_W'(cnt);
        back_we   = (cnt != '0);
      end
      ST_FILL: begin
        back_re   = (cnt != CNT_LAST);
        res_we    = (cnt != '0);
        res_waddr = slot_base_q + RIDX_W'(cnt_prev);
        res_wdata = back_rd;
      end
      ST_READ: begin
        res_re = 1'b1;
      end
      ST_MODIFY: begin
        res_we = load && !refuse_q && modify;
        tag_we = load && !refuse_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      dec_go    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      dec_go <= accept;
      if (state == ST_CLEAR) clr_cnt <= clr_cnt + CLR_W'(1);
      if (load) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q <= req.req_type;
      addr_q <= req.word_address;
      opnd_q <= WORD_BITS'(req.operand);
    end
    if ((state == ST_DECODE) && d3_v) begin
      key_q       <= KEY_W'(d2_q);
      ridx_q      <= RIDX_W'(d2_r);
      slot_q      <= SLOT_W'(d3_q);
      slot_base_q <= RIDX_W'(d2_r - d3_r);
      new_base_q  <= BACK_W'(d1_r - d3_r);
      refuse_q    <= refuse_now;
    end
    if (state == ST_TAG) begin
      hit_q       <= tag_hit;
      wb_q        <= !tag_hit && tag_rd.dirty;
      old_dirty_q <= tag_rd.dirty;
      old_base_q  <= BACK_W'(32'(tag_rd.key) * RES_DEPTH + 32'(slot_base_q));
      cnt         <= '0;
    end
    if ((state == ST_WB) || (state == ST_FILL)) begin
      cnt <= (cnt == CNT_LAST) ? '0 : cnt + CNT_W'(1);
    end
    if (load) begin
      out_data   <= refuse_q ? '0 : DATA_BITS'(new_word);
      out_status <= refuse_q ? STATUS_REFUSED : STATUS_DONE;
      out_hit    <= !refuse_q && hit_q;
      out_wb     <= !refuse_q && wb_q;
    end
  end

  always_ff @(posedge clk) begin
    if (res_we) res_mem[res_waddr] <= res_wdata;
    if (res_re) res_rd <= res_mem[res_raddr];
  end

  always_ff @(posedge clk) begin
    if (back_we) back_mem[back_waddr] <= back_wdata;
    if (back_re) back_rd <= back_mem[back_raddr];
  end

  always_ff @(posedge clk) begin
    if (tag_we) tag_mem[tag_waddr] <= tag_wdata;
    if (tag_re) tag_rd <= tag_mem[tag_raddr];
  end

  a_hit_no_wb: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.was_hit) |-> !rsp.did_writeback)
    else $error("write-back reported on a hit");

  a_refused_clean: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.status == STATUS_REFUSED)) |->
      ((rsp.data_out == '0) && !rsp.was_hit && !rsp.did_writeback))
    else $error("refused write carries data or flags");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_WB) || (state == ST_FILL)) |-> (cnt <= CNT_LAST))
    else $error("page copy counter out of range");

  a_wb_to_fill: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_WB) && (cnt == CNT_LAST)) |=> ((state == ST_FILL) && (cnt == '0)))
    else $error("fill did not start cleanly after write-back");

  a_load_done: assert property (@(posedge clk) disable iff (rst)
    load |=> ((state == ST_IDLE) && out_valid))
    else $error("result load did not finish the access");

endmodule

// ===== sim/tb_direct_mapped_writeback_page_cache.sv =====
`timescale 1ns / 1ps

module tb_direct_mapped_writeback_page_cache;
  import dmwpc_pkg::*;

  localparam int PAGE_WORDS = 64;
  localparam int SLOTS      = 16;
  localparam int KEYS       = 16;
  localparam int TOTAL      = PAGE_WORDS * SLOTS * KEYS;
  localparam int RANDOM_WORDS = 1200;

  // codes 6 and 7 have no meaning of their own and behave as a read
  localparam logic [TYPE_BITS-1:0] KIND_SPARE6 = 3'd6;
  localparam logic [TYPE_BITS-1:0] KIND_SPARE7 = 3'd7;

  typedef struct packed {
    logic [DATA_BITS-1:0] data_out;
    logic                 status;
    logic                 was_hit;
    logic                 did_writeback;
  } cache_rsp_t;

  logic clk = 1'b0;
  logic rst;

  dmwpc_req_if req_ch ();
  dmwpc_rsp_if rsp_ch ();

  direct_mapped_writeback_page_cache #(
    .WORDS_PER_PAGE(PAGE_WORDS),
    .RESIDENT_PAGES(SLOTS),
    .PAGE_KEYS(KEYS),
    .WORD_BITS(DATA_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // mirror of the cache contents
  logic [3:0]           page_tag [SLOTS];
  logic                 page_dirty [SLOTS];
  logic [DATA_BITS-1:0] resident_mem [SLOTS * PAGE_WORDS];
  logic [DATA_BITS-1:0] backing_mem [TOTAL];

  cache_rsp_t owed_responses[$];
  int  error_count = 0;
  bit  sender_calm = 1'b0;
  int  stall_left = 0;
  int  rsp_cycle = 0;

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic cache_rsp_t page_cache_access(logic [TYPE_BITS-1:0] kind,
                                                   logic [ADDR_BITS-1:0] addr,
                                                   logic [OPND_BITS-1:0] opnd);
    cache_rsp_t r;
    int page, ofs, slot, key, rbase, base, i;
    logic [DATA_BITS-1:0] w;
    r = '0;
    if (kind == KIND_WRITE && addr == 0) begin
      r.status = STATUS_REFUSED;
      return r;
    end
    page  = int'(addr) % TOTAL / PAGE_WORDS;
    ofs   = int'(addr) % PAGE_WORDS;
    slot  = page % SLOTS;
    key   = page / SLOTS;
    rbase = slot * PAGE_WORDS;
    r.status  = STATUS_DONE;
    r.was_hit = (int'(page_tag[slot]) == key);
    if (!r.was_hit) begin
      if (page_dirty[slot]) begin
        base = (int'(page_tag[slot]) * SLOTS + slot) * PAGE_WORDS;
        for (i = 0; i < PAGE_WORDS; i++) backing_mem[base + i] = resident_mem[rbase + i];
        r.did_writeback = 1'b1;
      end
      base = (key * SLOTS + slot) * PAGE_WORDS;
      for (i = 0; i < PAGE_WORDS; i++) resident_mem[rbase + i] = backing_mem[base + i];
      page_tag[slot]   = 4'(key);
      page_dirty[slot] = 1'b0;
    end
    w = resident_mem[rbase + ofs];
    case (kind)
      KIND_WRITE: w = opnd;
      KIND_INC:   w = w + 1;
      KIND_ADD:   w = w + opnd;
      KIND_DEC:   w = w - 1;
      KIND_SUB:   w = w - opnd;
      default:    ;
    endcase
    if (kind >= KIND_WRITE && kind <= KIND_SUB) begin
      resident_mem[rbase + ofs] = w;
      page_dirty[slot] = 1'b1;
    end
    r.data_out = w;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_word(input logic [TYPE_BITS-1:0] kind, input logic [ADDR_BITS-1:0] addr,
                           input logic [OPND_BITS-1:0] opnd);
    int   gap;
    logic taken;
    gap = sender_calm ? 0 : pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    owed_responses.push_back(page_cache_access(kind, addr, opnd));
    req_ch.valid        <= 1'b1;
    req_ch.req_type     <= kind;
    req_ch.word_address <= addr;
    req_ch.operand      <= opnd;
    // ready is stable by the falling edge, so sample it there
    do begin
      @(negedge clk);
      taken = req_ch.ready;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic check_field(input string name, input logic [DATA_BITS-1:0] expv,
                             input logic [DATA_BITS-1:0] actv);
    if (expv !== actv) begin
      $display("%0t: %s expected %h actual %h", $time, name, expv, actv);
      error_count++;
    end
  endtask

  always @(negedge clk) begin
    cache_rsp_t want;
    if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (owed_responses.size() == 0) begin
        $display("%0t: unexpected response data_out %h status %b", $time, rsp_ch.data_out,
                 rsp_ch.status);
        error_count++;
      end else begin
        want = owed_responses.pop_front();
        check_field("data_out", want.data_out, rsp_ch.data_out);
        check_field("status", 32'(want.status), 32'(rsp_ch.status));
        check_field("was_hit", 32'(want.was_hit), 32'(rsp_ch.was_hit));
        check_field("did_writeback", 32'(want.did_writeback), 32'(rsp_ch.did_writeback));
      end
    end
  end

  // response backpressure, with a stall-free stretch in every third window of rsp_cycle
  always @(posedge clk) begin
    int r;
    rsp_cycle++;
    if (stall_left > 0) begin
      stall_left--;
      rsp_ch.ready <= 1'b0;
    end else if ((rsp_cycle / 600) % 3 == 2) begin
      rsp_ch.ready <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        rsp_ch.ready <= 1'b1;
      end else begin
        stall_left = (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 40);
        rsp_ch.ready <= 1'b0;
      end
    end
  end

  task automatic test_refused_write();
    send_word(KIND_WRITE, '0, 32'hFFFF_FFFF);
    send_word(KIND_READ, '0, 32'h0);
    send_word(KIND_INC, '0, 32'h0);
    send_word(KIND_ADD, '0, 32'h7FFF_FFFF);
    send_word(KIND_DEC, '0, 32'hFFFF_FFFF);
    send_word(KIND_SUB, '0, 32'hFFFF_FFFF);
  endtask

  task automatic test_each_operation();
    logic [ADDR_BITS-1:0] a;
    a = 14'h0155;
    send_word(KIND_WRITE, a, 32'hFFFF_FFFF);
    send_word(KIND_INC, a, 32'h0);
    send_word(KIND_DEC, a, 32'h0);
    send_word(KIND_ADD, a, 32'h8000_0000);
    send_word(KIND_SUB, a, 32'h8000_0001);
    send_word(KIND_READ, a, 32'hFFFF_FFFF);
    send_word(KIND_SPARE6, a, 32'h1234_5678);
    send_word(KIND_SPARE7, a, 32'h8765_4321);
  endtask

  task automatic test_page_eviction();
    // top page of the last slot, then a conflicting page in the same slot
    send_word(KIND_WRITE, 14'h3FFF, 32'h1234_5678);
    send_word(KIND_READ, 14'h3FC0, 32'h0);
    send_word(KIND_READ, 14'h03FF, 32'h0);
    send_word(KIND_READ, 14'h3FFF, 32'h0);
    send_word(KIND_SUB, 14'h3FFF, 32'h0);
  endtask

  task automatic test_random_traffic();
    int n, r;
    logic [TYPE_BITS-1:0] kind;
    logic [ADDR_BITS-1:0] addr;
    logic [OPND_BITS-1:0] opnd;
    for (n = 0; n < RANDOM_WORDS; n++) begin
      sender_calm = ((n / 150) % 4 == 3);
      r = $urandom_range(0, 99);
      kind = (r < 6) ? TYPE_BITS'($urandom_range(6, 7)) : TYPE_BITS'($urandom_range(0, 5));
      r = $urandom_range(0, 99);
      // mostly a few keys fighting over a few slots, so pages go out and come back
      if (r < 3)
        addr = '0;
      else if (r < 75)
        addr = {4'($urandom_range(0, 3) * 5), 4'($urandom_range(0, 3)), 6'($urandom_range(0, 7))};
      else
        addr = ADDR_BITS'($urandom_range(0, TOTAL - 1));
      r = $urandom_range(0, 99);
      case (r % 4)
        0: opnd = 32'h0;
        1: opnd = 32'h1;
        2: opnd = 32'hFFFF_FFFF;
        default: opnd = 32'h8000_0000;
      endcase
      if (r >= 25) opnd = $urandom;
      send_word(kind, addr, opnd);
    end
    sender_calm = 1'b0;
  endtask

  initial begin
    int i;
    rst                 = 1'b1;
    req_ch.valid        = 1'b0;
    req_ch.req_type     = KIND_READ;
    req_ch.word_address = '0;
    req_ch.operand      = '0;
    rsp_ch.ready        = 1'b0;
    for (i = 0; i < SLOTS; i++) begin
      page_tag[i]   = '0;
      page_dirty[i] = 1'b0;
    end
    for (i = 0; i < SLOTS * PAGE_WORDS; i++) resident_mem[i] = '0;
    for (i = 0; i < TOTAL; i++) backing_mem[i] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_refused_write();
    test_each_operation();
    test_page_eviction();
    test_random_traffic();

    req_ch.valid <= 1'b0;
    while (owed_responses.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (error_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  initial begin
    #3000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/dmwpc_pkg.sv
rtl/dmwpc_req_if.sv
rtl/dmwpc_rsp_if.sv
rtl/dmwpc_cdiv.sv
rtl/direct_mapped_writeback_page_cache.sv
sim/tb_direct_mapped_writeback_page_cache.sv
